// File: rtl/core/gda_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and calendar helpers for the date arithmetic unit.
package gda_pkg;

  // Scaled reciprocal of 400: floor(y * Recip400 >> Recip400Shift) == y / 400
  // for every 14-bit year.
  localparam logic [15:0] Recip400      = 16'd41944;
  localparam int unsigned Recip400Shift = 24;
  localparam logic [8:0]  LastMod400    = 9'd399;
  localparam logic [22:0] CountMax      = 23'h3FFFFF;
  localparam logic [3:0]  MonthDec      = 4'd12;

  typedef logic [13:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;
  typedef logic [19:0] offset_t;
  typedef logic [22:0] count_t;
  typedef logic [8:0]  doy_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QUOT,
    S_REM,
    S_PREP,
    S_ADD,
    S_DIFF,
    S_TGT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic    op;
    year_t   base_year;
    month_t  base_month;
    day_t    base_day;
    offset_t day_offset;
    year_t   target_year;
    month_t  target_month;
    day_t    target_day;
  } in_item_t;

  typedef struct packed {
    year_t  result_year;
    month_t result_month;
    day_t   result_day;
    count_t day_count;
    logic   error;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic quot;
    logic rem;
    logic prep;
    logic add_step;
    logic diff_step;
    logic tgt;
    logic fin;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op;
    logic walk_done;
    logic out_busy;
  } sts_t;

  function automatic month_t fix_month(input month_t m);
    month_t r;
    if (m == 4'd0) begin
      r = 4'd1;
    end else if (m > MonthDec) begin
      r = MonthDec;
    end else begin
      r = m;
    end
    return r;
  endfunction

  // leap test on the year mod 400
  function automatic logic is_leap(input logic [8:0] r);
    return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  function automatic day_t month_len(input logic leap, input month_t m);
    day_t len;
    case (m)
      4'd2:                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the months before m
  function automatic doy_t days_before(input logic leap, input month_t m);
    doy_t base;
    case (m)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + ((leap && (m > 4'd2)) ? 9'd1 : 9'd0);
  endfunction

endpackage

// File: rtl/core/gda_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for date items and results.
interface gda_in_if import gda_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    op;
  year_t   base_year;
  month_t  base_month;
  day_t    base_day;
  offset_t day_offset;
  year_t   target_year;
  month_t  target_month;
  day_t    target_day;

  modport source (
    output valid, op, base_year, base_month, base_day, day_offset,
           target_year, target_month, target_day,
    input  ready
  );
  modport sink (
    input  valid, op, base_year, base_month, base_day, day_offset,
           target_year, target_month, target_day,
    output ready
  );
endinterface

interface gda_out_if import gda_pkg::*; ();
  logic   valid;
  logic   ready;
  year_t  result_year;
  month_t result_month;
  day_t   result_day;
  count_t day_count;
  logic   error;

  modport source (
    output valid, result_year, result_month, result_day, day_count, error,
    input  ready
  );
  modport sink (
    input  valid, result_year, result_month, result_day, day_count, error,
    output ready
  );
endinterface

// File: rtl/core/gda_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the date unit: steps the datapath through one item.
module gda_ctrl import gda_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_QUOT;
      S_QUOT: state_nxt = S_REM;
      S_REM:  state_nxt = S_PREP;
      S_PREP: state_nxt = sts.op ? S_DIFF : S_ADD;
      S_ADD:  if (sts.walk_done) state_nxt = S_FIN;
      S_DIFF: if (sts.walk_done) state_nxt = S_TGT;
      S_TGT:  state_nxt = S_FIN;
      S_FIN:  if (!sts.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_QUOT: cmd.quot      = 1'b1;
      S_REM:  cmd.rem       = 1'b1;
      S_PREP: cmd.prep      = 1'b1;
      S_ADD:  cmd.add_step  = !sts.walk_done;
      S_DIFF: cmd.diff_step = !sts.walk_done;
      S_TGT:  cmd.tgt       = 1'b1;
      S_FIN:  cmd.fin       = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/core/gda_dp.sv
`timescale 1ns / 1ps
// Datapath: date registers, year mod 400 tracking, month and year walks, result register.
module gda_dp import gda_pkg::*; #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  in_item_t  in_item,
  input  logic      out_ready,
  output sts_t      sts,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam logic [16:0] MaxYearC = MAX_YEAR[16:0];

  logic        op_r, op_nxt;
  logic [14:0] y_r, y_nxt;
  month_t      m_r, m_nxt;
  day_t        d_r, d_nxt;
  offset_t     left_r, left_nxt;
  year_t       ty_r, ty_nxt;
  month_t      tm_r, tm_nxt;
  day_t        td_r, td_nxt;
  logic [5:0]  q_r, q_nxt;
  logic [8:0]  r400_r, r400_nxt;
  logic        err_r, err_nxt;
  doy_t        doy_a_r, doy_a_nxt;
  doy_t        doy_b_r, doy_b_nxt;
  logic [23:0] years_r, years_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic        leap_c;
  day_t        len_c, tlen_c, dfix_c, tdfix_c, rest_c;
  logic [14:0] y_inc_c;
  logic [8:0]  r400_inc_c;
  logic [29:0] prod_c;
  logic [15:0] rem_c;
  logic [24:0] sum_c;
  count_t      count_c;

  assign leap_c     = is_leap(r400_r);
  assign len_c      = month_len(leap_c, m_r);
  assign tlen_c     = month_len(leap_c, tm_r);
  assign dfix_c     = (d_r == 5'd0) ? 5'd1 : ((d_r > len_c) ? len_c : d_r);
  assign tdfix_c    = (td_r == 5'd0) ? 5'd1 : ((td_r > tlen_c) ? tlen_c : td_r);
  assign rest_c     = len_c - d_r;
  assign y_inc_c    = y_r + 15'd1;
  assign r400_inc_c = (r400_r == LastMod400) ? 9'd0 : r400_r + 9'd1;
  assign prod_c     = 30'(y_r[13:0]) * 30'(Recip400);
  assign rem_c      = 16'(y_r) - 16'(q_r) * 16'd400;
  assign sum_c      = {1'b0, years_r} + 25'(doy_b_r) - 25'(doy_a_r);

  always_comb begin
    if (sum_c[24]) begin
      count_c = sum_c[22:0];
    end else if (sum_c[23:0] > 24'(CountMax)) begin
      count_c = CountMax;
    end else begin
      count_c = sum_c[22:0];
    end
  end

  always_comb begin
    op_nxt    = op_r;
    y_nxt     = y_r;
    m_nxt     = m_r;
    d_nxt     = d_r;
    left_nxt  = left_r;
    ty_nxt    = ty_r;
    tm_nxt    = tm_r;
    td_nxt    = td_r;
    q_nxt     = q_r;
    r400_nxt  = r400_r;
    err_nxt   = err_r;
    doy_a_nxt = doy_a_r;
    doy_b_nxt = doy_b_r;
    years_nxt = years_r;
    out_item_nxt = out_item_r;
    if (cmd.load) begin
      op_nxt   = in_item.op;
      y_nxt    = {1'b0, in_item.base_year};
      m_nxt    = fix_month(in_item.base_month);
      d_nxt    = in_item.base_day;
      left_nxt = in_item.day_offset;
      ty_nxt   = in_item.target_year;
      tm_nxt   = fix_month(in_item.target_month);
      td_nxt   = in_item.target_day;
      err_nxt  = 1'b0;
    end
    if (cmd.quot) begin
      q_nxt = prod_c[29:Recip400Shift];
    end
    if (cmd.rem) begin
      r400_nxt = rem_c[8:0];
    end
    if (cmd.prep) begin
      d_nxt     = dfix_c;
      doy_a_nxt = days_before(leap_c, m_r) + 9'(dfix_c);
      years_nxt = '0;
      err_nxt   = op_r ? (ty_r < y_r[13:0]) : ({2'b00, y_r} > MaxYearC);
    end
    if (cmd.add_step) begin
      if (left_r > 20'(rest_c)) begin
        left_nxt = left_r - 20'(rest_c) - 20'd1;
        d_nxt    = 5'd1;
        if (m_r == MonthDec) begin
          m_nxt    = 4'd1;
          y_nxt    = y_inc_c;
          r400_nxt = r400_inc_c;
          if ({2'b00, y_inc_c} > MaxYearC) begin
            err_nxt = 1'b1;
          end
        end else begin
          m_nxt = m_r + 4'd1;
        end
      end else begin
        d_nxt    = d_r + left_r[4:0];
        left_nxt = '0;
      end
    end
    if (cmd.diff_step) begin
      years_nxt = years_r + (leap_c ? 24'd366 : 24'd365);
      y_nxt     = y_inc_c;
      r400_nxt  = r400_inc_c;
    end
    if (cmd.tgt) begin
      doy_b_nxt = days_before(leap_c, tm_r) + 9'(tdfix_c);
    end
    if (cmd.fin) begin
      out_item_nxt       = '0;
      out_item_nxt.error = err_r;
      if (!err_r) begin
        if (op_r) begin
          out_item_nxt.day_count = count_c;
        end else begin
          out_item_nxt.result_year  = y_r[13:0];
          out_item_nxt.result_month = m_r;
          out_item_nxt.result_day   = d_r;
        end
      end
    end
  end

  always_comb begin
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    y_r        <= y_nxt;
    m_r        <= m_nxt;
    d_r        <= d_nxt;
    left_r     <= left_nxt;
    ty_r       <= ty_nxt;
    tm_r       <= tm_nxt;
    td_r       <= td_nxt;
    q_r        <= q_nxt;
    r400_r     <= r400_nxt;
    err_r      <= err_nxt;
    doy_a_r    <= doy_a_nxt;
    doy_b_r    <= doy_b_nxt;
    years_r    <= years_nxt;
    out_item_r <= out_item_nxt;
  end

  assign sts.op        = op_r;
  assign sts.walk_done = err_r || (op_r ? ({1'b0, ty_r} <= y_r) : (left_r == '0));
  assign sts.out_busy  = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_item      = out_item_r;

endmodule

// File: rtl/core/gregorian_date_arithmetic.sv
`timescale 1ns / 1ps
// Top level of the Gregorian date add / difference unit.
//
//  channel  dir  handshake          beat contents
//  -------  ---  -----------------  ----------------------------------------------
//  in_ch    in   valid/ready        op, base date, day_offset, target date
//  out_ch   out  valid/ready        result date, signed day_count, error
//
//  Sequencing: one item at a time. Add walks the months crossed, with one more
//  step when the offset ends inside a month; difference walks one year per
//  step from base_year up to target_year.
//  The walk loop in the datapath advances one month or one year per cycle.
//  Reset: synchronous, active low; clears the sequencer and the output valid.
//  Stalls: a finished result sits in the output register; the next beat is
//  taken while it waits, and the unit holds in its final step only if the
//  previous result is still not taken.
module gregorian_date_arithmetic import gda_pkg::*; #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic     clk,
  input  logic     rst_n,
  gda_in_if.sink   in_ch,
  gda_out_if.source out_ch
);

  cmd_t      cmd;
  sts_t      sts;
  in_item_t  in_item;
  out_item_t out_item;
  logic      out_valid;
  logic      in_ready;

  // pack the input beat
  assign in_item.op           = in_ch.op;
  assign in_item.base_year    = in_ch.base_year;
  assign in_item.base_month   = in_ch.base_month;
  assign in_item.base_day     = in_ch.base_day;
  assign in_item.day_offset   = in_ch.day_offset;
  assign in_item.target_year  = in_ch.target_year;
  assign in_item.target_month = in_ch.target_month;
  assign in_item.target_day   = in_ch.target_day;
  assign in_ch.ready          = in_ready;

  // sequencer: load, year mod 400 (two steps), clamp, walk, target (difference only), finish
  gda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: holds the walked date, the year accumulator and the result register
  gda_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // unpack the result beat
  assign out_ch.valid        = out_valid;
  assign out_ch.result_year  = out_item.result_year;
  assign out_ch.result_month = out_item.result_month;
  assign out_ch.result_day   = out_item.result_day;
  assign out_ch.day_count    = out_item.day_count;
  assign out_ch.error        = out_item.error;

  // one item in flight: no new beat right after one is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while an item is in flight");

  // an error result carries no date
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.error |->
      (out_ch.result_year == '0) && (out_ch.result_month == '0) &&
      (out_ch.result_day == '0) && (out_ch.day_count == '0))
    else $error("error result with nonzero fields");

  // a produced date has a legal month and a nonzero day
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.result_month != '0) |->
      (out_ch.result_month <= MonthDec) && (out_ch.result_day != '0))
    else $error("result date out of range");

endmodule
